### rtl/assert_macros.svh
// Assertion helpers shared by the oscillator RTL.
// No dependencies; pulled in by the modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define MWSO_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define MWSO_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/mwso_pkg.sv
// Shared types, constants and the sine table generator for the stereo oscillator.
// No dependencies; used by all oscillator modules.
`timescale 1ns / 1ps
`default_nettype none

package mwso_pkg;

  localparam int SAMPLE_W    = 16;            // output sample width
  localparam int RAW_W       = SAMPLE_W + 1;  // raw sample spans [-FS, FS]
  localparam int SINE_ADDR_W = 8;
  localparam int SINE_LEN    = 1 << SINE_ADDR_W;
  localparam int STEP_W      = 32;
  localparam int SHAPE_W     = 3;
  localparam int GAIN_W      = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int LFSR_W      = 32;

  localparam logic [RAW_W-1:0] FS_POS = RAW_W'(1 << (SAMPLE_W - 1));
  localparam logic [RAW_W-1:0] FS_NEG = RAW_W'(-(1 << (SAMPLE_W - 1)));

  localparam logic [LFSR_W-1:0] LFSR_SEED = 32'hACE1_ACE1;
  localparam logic [LFSR_W-1:0] LFSR_TAPS = 32'h8020_0003;

  localparam logic [STEP_W-1:0]  RST_PHASE_STEP = 32'd42852281;
  localparam logic [GAIN_W-1:0]  RST_AMPLITUDE  = 16'd16384;
  localparam logic [GAIN_W-1:0]  RST_PAN        = 16'd16384;
  localparam logic [GAIN_W-1:0]  UNITY_GAIN     = 16'd32768;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [SHAPE_W-1:0] {
    SHAPE_SINE     = 3'd0,
    SHAPE_SAW      = 3'd1,
    SHAPE_SQUARE   = 3'd2,
    SHAPE_TRIANGLE = 3'd3,
    SHAPE_NOISE    = 3'd4
  } wave_shape_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHASE_STEP = 3'd0,
    CFG_WAVE_SHAPE = 3'd1,
    CFG_AMPLITUDE  = 3'd2,
    CFG_PAN        = 3'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_AMP,
    BK_LEFT,
    BK_RIGHT,
    BK_EMIT
  } back_state_e;

  // One raw sample moving through the front/back queue.
  typedef struct packed {
    logic                    valid;
    logic signed [RAW_W-1:0] sample;
  } smp_xfer_t;

  // Quarter-wave sine entry: Q30 Taylor series up to x^11, rounded to Q1.15.
  // Only evaluated at elaboration.
  function automatic logic [RAW_W-1:0] sine_entry(input int unsigned k);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    x    = ((64'(2 * k + 1) * HALF_PI_Q30) + (64'd1 << SINE_ADDR_W)) >> (SINE_ADDR_W + 1);
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - $signed(term);
    if (sum < 0) sum = 64'sd0;
    sum = (sum + (64'sd1 <<< (30 - SAMPLE_W))) >>> (31 - SAMPLE_W);
    if (sum > 64'sd32768) sum = 64'sd32768;
    return sum[RAW_W-1:0];
  endfunction

  // Floor-shifted product to the signed output range.
  function automatic logic [SAMPLE_W-1:0] sat_sample(input logic signed [20:0] v);
    logic [SAMPLE_W-1:0] r;
    if (v > 21'sd32767) begin
      r = 16'h7FFF;
    end else if (v < -21'sd32768) begin
      r = 16'h8000;
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/mwso_front.sv
// Front end: takes tick transactions, steps phase accumulator and noise LFSR,
// shapes one raw sample and pushes it to the queue. Depends on mwso_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mwso_front #(
  parameter int PHASE_BITS = 32
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output      logic                             in_stall_o,
  input  wire logic                             tick_i,
  input  wire logic [mwso_pkg::STEP_W-1:0]      phase_step_i,
  input  wire logic [mwso_pkg::SHAPE_W-1:0]     wave_shape_i,
  input  wire logic                             fifo_full_i,
  output      mwso_pkg::smp_xfer_t              push_o
);

  localparam int SUM_W = (PHASE_BITS > mwso_pkg::STEP_W) ? PHASE_BITS : mwso_pkg::STEP_W;
  localparam int SW    = mwso_pkg::SAMPLE_W;
  localparam int RW    = mwso_pkg::RAW_W;
  localparam int AW    = mwso_pkg::SINE_ADDR_W;

  logic [PHASE_BITS-1:0]           phase_q, phase_d;
  logic [mwso_pkg::LFSR_W-1:0]     lfsr_q, lfsr_d;
  logic                            pending_q, pending_d;
  logic [SUM_W-1:0]                phase_sum;
  logic                            take;
  logic                            push;

  logic [RW-1:0]                   sine_rom [mwso_pkg::SINE_LEN];
  logic [SW-1:0]                   u;
  logic [1:0]                      quad;
  logic [AW-1:0]                   sine_idx;
  logic [RW-1:0]                   sine_mag;
  logic [RW-1:0]                   sample;

  for (genvar k = 0; k < mwso_pkg::SINE_LEN; k++) begin : g_rom
    localparam logic [RW-1:0] ENTRY = mwso_pkg::sine_entry(k);
    assign sine_rom[k] = ENTRY;
  end

  assign in_stall_o = pending_q & fifo_full_i;
  assign take       = in_valid_i & ~in_stall_o & tick_i;
  assign push       = pending_q & ~fifo_full_i;

  always_comb begin
    phase_sum = SUM_W'(phase_q) + SUM_W'(phase_step_i);
    phase_d   = phase_q;
    lfsr_d    = lfsr_q;
    pending_d = pending_q;
    if (push) pending_d = 1'b0;
    if (take) begin
      phase_d   = phase_sum[PHASE_BITS-1:0];
      lfsr_d    = {1'b0, lfsr_q[mwso_pkg::LFSR_W-1:1]}
                ^ (lfsr_q[0] ? mwso_pkg::LFSR_TAPS : '0);
      pending_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= '0;
      lfsr_q    <= mwso_pkg::LFSR_SEED;
      pending_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      lfsr_q    <= lfsr_d;
      pending_q <= pending_d;
    end
  end

  // Sample shaping from the registered phase of the pending tick.
  assign u        = phase_q[PHASE_BITS-1 -: SW];
  assign quad     = phase_q[PHASE_BITS-1 -: 2];
  assign sine_idx = quad[0] ? ~phase_q[PHASE_BITS-3 -: AW] : phase_q[PHASE_BITS-3 -: AW];
  assign sine_mag = sine_rom[sine_idx];

  always_comb begin
    case (mwso_pkg::wave_shape_e'(wave_shape_i))
      mwso_pkg::SHAPE_SINE:     sample = quad[1] ? RW'(~sine_mag + 1'b1) : sine_mag;
      mwso_pkg::SHAPE_SAW:      sample = RW'({1'b0, mwso_pkg::FS_POS} - (RW + 1)'(u));
      mwso_pkg::SHAPE_SQUARE:   sample = u[SW-1] ? mwso_pkg::FS_POS : mwso_pkg::FS_NEG;
      mwso_pkg::SHAPE_TRIANGLE: begin
        if (!u[SW-1]) begin
          sample = RW'({1'b0, mwso_pkg::FS_POS} - (RW + 1)'({u, 1'b0}));
        end else begin
          sample = RW'((RW + 1)'({u, 1'b0}) - (RW + 1)'(3 * (1 << (SW - 1))));
        end
      end
      mwso_pkg::SHAPE_NOISE:    sample = {lfsr_q[mwso_pkg::LFSR_W-1],
                                          lfsr_q[mwso_pkg::LFSR_W-1 -: SW]};
      default:                  sample = '0;
    endcase
  end

  assign push_o.valid  = push;
  assign push_o.sample = $signed(sample);

endmodule

`default_nettype wire

### rtl/mwso_fifo.sv
// Two-entry queue of raw samples between front end and scaling back end.
// Depends on mwso_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mwso_fifo (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire mwso_pkg::smp_xfer_t push_i,
  input  wire logic                pop_i,
  output      mwso_pkg::smp_xfer_t head_o,
  output      logic                full_o
);

  localparam int DEPTH = 2;

  logic signed [mwso_pkg::RAW_W-1:0] mem_q [DEPTH];
  logic                              wr_ptr_q, rd_ptr_q;
  logic [1:0]                        count_q, count_d;
  logic                              do_push, do_pop;

  assign full_o      = (count_q == 2'(DEPTH));
  assign head_o.valid  = (count_q != 2'd0);
  assign head_o.sample = mem_q[rd_ptr_q];
  assign do_push     = push_i.valid & ~full_o;
  assign do_pop      = pop_i & head_o.valid;

  always_comb begin
    count_d = count_q;
    if (do_push & ~do_pop) count_d = count_q + 2'd1;
    if (do_pop & ~do_push) count_d = count_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_i.sample;
  end

  `MWSO_ASSERT(a_no_overflow, clk_i, rst_ni, !(push_i.valid && full_o), "push into full queue")
  `MWSO_ASSERT_ALWAYS(a_count_bound, clk_i, !rst_ni || count_q <= 2'd2, "queue count out of range")

endmodule

`default_nettype wire

### rtl/mwso_back.sv
// Back end: one shared multiplier forms sample*amplitude, then the left and
// right pan products; floors, saturates and holds the frame. Depends on mwso_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mwso_back (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire mwso_pkg::smp_xfer_t             head_i,
  output      logic                            pop_o,
  input  wire logic [mwso_pkg::GAIN_W-1:0]     amplitude_i,
  input  wire logic [mwso_pkg::GAIN_W-1:0]     pan_i,
  output      logic                            out_valid_o,
  input  wire logic                            out_stall_i,
  output      logic [mwso_pkg::SAMPLE_W-1:0]   left_sample_o,
  output      logic [mwso_pkg::SAMPLE_W-1:0]   right_sample_o
);

  localparam int SW = mwso_pkg::SAMPLE_W;

  mwso_pkg::back_state_e             state_q, state_d;
  logic signed [mwso_pkg::RAW_W-1:0] s_q;
  logic signed [32:0]                gain_q;
  logic [SW-1:0]                     left_res_q, right_res_q;
  logic [SW-1:0]                     left_q, right_q;
  logic                              out_valid_q, out_valid_d;
  logic [mwso_pkg::GAIN_W-1:0]       left_w, right_w;
  logic signed [32:0]                mul_a;
  logic signed [17:0]                mul_b;
  logic signed [50:0]                prod;
  logic                              out_free;
  logic                              load_out;

  // Pan above unity clamps to unity.
  assign left_w   = (pan_i > mwso_pkg::UNITY_GAIN) ? mwso_pkg::UNITY_GAIN : pan_i;
  assign right_w  = mwso_pkg::UNITY_GAIN - left_w;
  assign out_free = ~out_valid_q | ~out_stall_i;
  assign prod     = 51'(mul_a) * 51'(mul_b);

  always_comb begin
    state_d  = state_q;
    pop_o    = 1'b0;
    load_out = 1'b0;
    mul_a    = gain_q;
    mul_b    = $signed({2'b00, left_w});
    case (state_q)
      mwso_pkg::BK_IDLE: begin
        if (head_i.valid) begin
          pop_o   = 1'b1;
          state_d = mwso_pkg::BK_AMP;
        end
      end
      mwso_pkg::BK_AMP: begin
        mul_a   = 33'(s_q);
        mul_b   = $signed({2'b00, amplitude_i});
        state_d = mwso_pkg::BK_LEFT;
      end
      mwso_pkg::BK_LEFT: begin
        state_d = mwso_pkg::BK_RIGHT;
      end
      mwso_pkg::BK_RIGHT: begin
        mul_b   = $signed({2'b00, right_w});
        state_d = mwso_pkg::BK_EMIT;
      end
      mwso_pkg::BK_EMIT: begin
        if (out_free) begin
          load_out = 1'b1;
          if (head_i.valid) begin
            pop_o   = 1'b1;
            state_d = mwso_pkg::BK_AMP;
          end else begin
            state_d = mwso_pkg::BK_IDLE;
          end
        end
      end
      default: state_d = mwso_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (load_out) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mwso_pkg::BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // prod[50:30] is the product floored by 2^30.
  always_ff @(posedge clk_i) begin
    if (pop_o) s_q <= head_i.sample;
    if (state_q == mwso_pkg::BK_AMP) gain_q <= $signed(prod[32:0]);
    if (state_q == mwso_pkg::BK_LEFT) left_res_q <= mwso_pkg::sat_sample($signed(prod[50:30]));
    if (state_q == mwso_pkg::BK_RIGHT) right_res_q <= mwso_pkg::sat_sample($signed(prod[50:30]));
    if (load_out) begin
      left_q  <= left_res_q;
      right_q <= right_res_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign left_sample_o  = left_q;
  assign right_sample_o = right_q;

  `MWSO_ASSERT(a_pop_starts_mul, clk_i, rst_ni, pop_o |=> state_q == mwso_pkg::BK_AMP, "pop without multiply")

endmodule

`default_nettype wire

### rtl/multi_waveform_stereo_oscillator.sv
// Stereo DDS oscillator, top level: configuration registers and the
// front / queue / back instances. Depends on mwso_pkg, mwso_front, mwso_fifo, mwso_back.
`timescale 1ns / 1ps
`default_nettype none

// Each input transaction with tick_i high steps the phase accumulator by
// phase_step and the noise LFSR once, and yields one stereo frame; tick_i low
// is taken and ignored. The front end takes a tick in any cycle its one-sample
// holding slot is free or drains into the two-entry queue, registers it in that
// slot and pushes the shaped sample once the queue has room; the back end runs
// the three products (gain, left pan, right pan) through one shared multiplier,
// so it takes a new sample only once the last frame has moved to the output register.
// Input stalls only while the holding slot waits on a full queue.
// Configuration writes are always ready, take effect at once and belong only
// in idle time; indexes beyond pan are dropped.
module multi_waveform_stereo_oscillator #(
  parameter int PHASE_BITS = 32
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output      logic                                in_stall_o,
  input  wire logic                                tick_i,
  output      logic                                out_valid_o,
  input  wire logic                                out_stall_i,
  output      logic signed [mwso_pkg::SAMPLE_W-1:0] left_sample_o,
  output      logic signed [mwso_pkg::SAMPLE_W-1:0] right_sample_o,
  input  wire logic                                cfg_valid_i,
  output      logic                                cfg_ready_o,
  input  wire logic [mwso_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [mwso_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  logic [mwso_pkg::STEP_W-1:0]   phase_step_q;
  logic [mwso_pkg::SHAPE_W-1:0]  wave_shape_q;
  logic [mwso_pkg::GAIN_W-1:0]   amplitude_q;
  logic [mwso_pkg::GAIN_W-1:0]   pan_q;
  logic                          cfg_we;

  mwso_pkg::smp_xfer_t           push;
  mwso_pkg::smp_xfer_t           head;
  logic                          fifo_full;
  logic                          pop;
  logic [mwso_pkg::SAMPLE_W-1:0] left_raw, right_raw;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q <= mwso_pkg::RST_PHASE_STEP;
      wave_shape_q <= mwso_pkg::SHAPE_SINE;
      amplitude_q  <= mwso_pkg::RST_AMPLITUDE;
      pan_q        <= mwso_pkg::RST_PAN;
    end else if (cfg_we) begin
      case (mwso_pkg::cfg_reg_e'(cfg_index_i))
        mwso_pkg::CFG_PHASE_STEP: phase_step_q <= cfg_data_i[mwso_pkg::STEP_W-1:0];
        mwso_pkg::CFG_WAVE_SHAPE: wave_shape_q <= cfg_data_i[mwso_pkg::SHAPE_W-1:0];
        mwso_pkg::CFG_AMPLITUDE:  amplitude_q  <= cfg_data_i[mwso_pkg::GAIN_W-1:0];
        mwso_pkg::CFG_PAN:        pan_q        <= cfg_data_i[mwso_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  mwso_front #(
    .PHASE_BITS (PHASE_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .tick_i       (tick_i),
    .phase_step_i (phase_step_q),
    .wave_shape_i (wave_shape_q),
    .fifo_full_i  (fifo_full),
    .push_o       (push)
  );

  mwso_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .head_o (head),
    .full_o (fifo_full)
  );

  mwso_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .pop_o          (pop),
    .amplitude_i    (amplitude_q),
    .pan_i          (pan_q),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .left_sample_o  (left_raw),
    .right_sample_o (right_raw)
  );

  assign left_sample_o  = $signed(left_raw);
  assign right_sample_o = $signed(right_raw);

endmodule

`default_nettype wire

### test/mwso_frame_checker.sv
// Frame checker for the stereo DDS oscillator: keeps its own copy of the oscillator
// state, predicts every stereo frame and compares it with what the block emits.
// Depends on mwso_pkg.
`timescale 1ns / 1ps

module mwso_frame_checker
  import mwso_pkg::*;
(
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  input  wire logic                       in_stall_i,
  input  wire logic                       tick_i,
  input  wire logic                       out_valid_i,
  input  wire logic                       out_stall_i,
  input  wire logic signed [SAMPLE_W-1:0] left_sample_i,
  input  wire logic signed [SAMPLE_W-1:0] right_sample_i,
  input  wire logic                       cfg_valid_i,
  input  wire logic                       cfg_ready_i,
  input  wire logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]      cfg_data_i,
  output int                              mismatch_count_o,
  output int                              frames_pending_o
);

  localparam longint FULL_SCALE  = longint'(1) << (SAMPLE_W - 1);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
  } stereo_frame_t;

  longint             sine_quarter [SINE_LEN];
  logic [STEP_W-1:0]  osc_phase;
  logic [LFSR_W-1:0]  noise_lfsr;
  logic [STEP_W-1:0]  step_reg;
  logic [SHAPE_W-1:0] shape_reg;
  logic [GAIN_W-1:0]  amp_reg;
  logic [GAIN_W-1:0]  pan_reg;
  stereo_frame_t      expected_frames [$];
  int                 mismatches = 0;
  int                 pending = 0;

  assign mismatch_count_o = mismatches;
  assign frames_pending_o = pending;

  // Quarter-wave table: Q30 Taylor series of sin up to x^11, rounded to the sample format.
  initial begin
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          acc;
    for (int k = 0; k < SINE_LEN; k++) begin
      x    = ((64'(2 * k + 1) * HALF_PI_Q30) + (64'd1 << SINE_ADDR_W)) >> (SINE_ADDR_W + 1);
      x2   = (x * x) >> 30;
      term = x;
      acc  = longint'(x);
      for (int n = 1; n <= 5; n++) begin
        term = ((term * x2) >> 30) / 64'(2 * n * (2 * n + 1));
        acc  = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
      end
      if (acc < 0) acc = 0;
      acc = (acc + (longint'(1) << (30 - SAMPLE_W))) >>> (31 - SAMPLE_W);
      sine_quarter[k] = (acc > FULL_SCALE) ? FULL_SCALE : acc;
    end
  end

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatches++;
  endtask

  // Gain and pan product, floored, then clipped to the signed sample range.
  function automatic logic signed [SAMPLE_W-1:0] scale_sample(input longint s,
                                                              input longint weight);
    longint v;
    v = (s * weight * longint'(amp_reg)) >>> 30;
    if (v > FULL_SCALE - 1) v = FULL_SCALE - 1;
    else if (v < -FULL_SCALE) v = -FULL_SCALE;
    return v[SAMPLE_W-1:0];
  endfunction

  // Advances phase and noise by one tick and returns the frame it yields.
  function automatic stereo_frame_t next_frame();
    longint                 u;
    longint                 s;
    longint                 left_w;
    logic [1:0]             quadrant;
    logic [SINE_ADDR_W-1:0] idx;
    logic                   shifted_out;
    stereo_frame_t          f;
    osc_phase   = osc_phase + step_reg;
    shifted_out = noise_lfsr[0];
    noise_lfsr  = noise_lfsr >> 1;
    if (shifted_out) noise_lfsr = noise_lfsr ^ LFSR_TAPS;
    u        = longint'(osc_phase[STEP_W-1 -: SAMPLE_W]);
    quadrant = osc_phase[STEP_W-1 -: 2];
    idx      = osc_phase[STEP_W-3 -: SINE_ADDR_W];
    case (shape_reg)
      SHAPE_SINE: begin
        if (quadrant[0]) idx = ~idx;  // odd quarters read the table backwards
        s = quadrant[1] ? -sine_quarter[idx] : sine_quarter[idx];
      end
      SHAPE_SAW:      s = FULL_SCALE - u;
      SHAPE_SQUARE:   s = (u < FULL_SCALE) ? -FULL_SCALE : FULL_SCALE;
      SHAPE_TRIANGLE: s = (u < FULL_SCALE) ? FULL_SCALE - 2 * u : 2 * u - 3 * FULL_SCALE;
      SHAPE_NOISE:    s = longint'($signed(noise_lfsr[LFSR_W-1 -: SAMPLE_W]));
      default:        s = 0;
    endcase
    left_w  = (pan_reg > UNITY_GAIN) ? longint'(UNITY_GAIN) : longint'(pan_reg);
    f.left  = scale_sample(s, left_w);
    f.right = scale_sample(s, longint'(UNITY_GAIN) - left_w);
    return f;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    stereo_frame_t want;
    if (!rst_ni) begin
      osc_phase  = '0;
      noise_lfsr = LFSR_SEED;
      step_reg   = RST_PHASE_STEP;
      shape_reg  = SHAPE_SINE;
      amp_reg    = RST_AMPLITUDE;
      pan_reg    = RST_PAN;
      expected_frames.delete();
      pending <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_PHASE_STEP: step_reg  = cfg_data_i[STEP_W-1:0];
          CFG_WAVE_SHAPE: shape_reg = cfg_data_i[SHAPE_W-1:0];
          CFG_AMPLITUDE:  amp_reg   = cfg_data_i[GAIN_W-1:0];
          CFG_PAN:        pan_reg   = cfg_data_i[GAIN_W-1:0];
          default: ;  // unmapped index, dropped
        endcase
      end
      if (in_valid_i && !in_stall_i && tick_i) expected_frames.push_back(next_frame());
      if (out_valid_i && !out_stall_i) begin
        if (expected_frames.size() == 0) begin
          report_mismatch($sformatf("frame with none expected: left %0d right %0d",
                                    left_sample_i, right_sample_i));
        end else begin
          want = expected_frames.pop_front();
          if (left_sample_i !== want.left)
            report_mismatch($sformatf("left sample %0d, expected %0d",
                                      left_sample_i, want.left));
          if (right_sample_i !== want.right)
            report_mismatch($sformatf("right sample %0d, expected %0d",
                                      right_sample_i, want.right));
        end
      end
      pending <= expected_frames.size();
    end
  end

endmodule

### test/multi_waveform_stereo_oscillator_test.sv
// Testbench top for the stereo DDS oscillator: clock, reset, tick and register
// stimulus, output back-pressure and the final verdict.
// Depends on mwso_pkg, multi_waveform_stereo_oscillator and mwso_frame_checker.
`timescale 1ns / 1ps

module multi_waveform_stereo_oscillator_test;
  import mwso_pkg::*;

  localparam int                 RANDOM_TICKS   = 800;
  localparam int                 IDLE_SETTLE    = 12;
  localparam int                 WATCHDOG_LIMIT = 2000;
  localparam logic [SHAPE_W-1:0] SHAPE_UNUSED   = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  tick = 1'b0;
  logic                  out_stall = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  wire                   in_stall;
  wire                   out_valid;
  wire                   cfg_ready;
  wire [SAMPLE_W-1:0]    left_sample;
  wire [SAMPLE_W-1:0]    right_sample;
  int                    mismatch_count;
  int                    frames_pending;
  logic [31:0]           stall_pattern = '0;
  int                    stall_left = 0;
  int                    quiet_cycles = 0;

  multi_waveform_stereo_oscillator DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .tick_i         (tick),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .left_sample_o  (left_sample),
    .right_sample_o (right_sample),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  mwso_frame_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .tick_i           (tick),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .left_sample_i    (left_sample),
    .right_sample_i   (right_sample),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatch_count),
    .frames_pending_o (frames_pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver back-pressure: a fresh random stall pattern each time the last one runs out, from none to heavy.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_left <= 31;
      case ($urandom_range(0, 3))
        0:       stall_pattern <= '0;
        1:       stall_pattern <= $urandom;
        2:       stall_pattern <= $urandom & $urandom;
        default: stall_pattern <= $urandom | $urandom;
      endcase
    end else begin
      stall_left    <= stall_left - 1;
      stall_pattern <= {stall_pattern[0], stall_pattern[31:1]};
    end
    out_stall <= stall_pattern[0];
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic push_item(input logic t);
    in_valid <= 1'b1;
    tick     <= t;
    do @(posedge clk); while (in_stall);
  endtask

  // Sends count ticks in bursts; tick-low items are mixed in and not counted.
  task automatic send_ticks(input int count);
    int   sent_ticks;
    int   burst;
    int   gap;
    bit   steady;
    logic t;
    sent_ticks = 0;
    steady     = ($urandom_range(0, 2) == 0);
    burst      = $urandom_range(1, 24);
    while (sent_ticks < count) begin
      t = ($urandom_range(0, 9) != 0);
      push_item(t);
      if (t) sent_ticks++;
      burst--;
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        gap   = steady ? 0 : $urandom_range(0, 12);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    in_valid <= 1'b0;
  endtask

  // Writes all four registers, optionally followed by a write to an unmapped index.
  task automatic set_config(input logic [STEP_W-1:0] step_val, input logic [SHAPE_W-1:0] shape,
                            input logic [GAIN_W-1:0] amp, input logic [GAIN_W-1:0] pan,
                            input bit stray);
    cfg_reg_e              regs [4];
    logic [CFG_DATA_W-1:0] vals [4];
    regs = '{CFG_PHASE_STEP, CFG_WAVE_SHAPE, CFG_AMPLITUDE, CFG_PAN};
    vals = '{step_val, CFG_DATA_W'(shape), CFG_DATA_W'(amp), CFG_DATA_W'(pan)};
    cfg_valid <= 1'b1;
    for (int r = 0; r < 4; r++) begin
      cfg_index <= regs[r];
      cfg_data  <= vals[r];
      do @(posedge clk); while (!cfg_ready);
    end
    if (stray) begin
      cfg_index <= CFG_IDX_W'($urandom_range(CFG_PAN + 1, (1 << CFG_IDX_W) - 1));
      cfg_data  <= $urandom;
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    @(posedge clk);
    while (frames_pending != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return UNITY_GAIN;
      2:       return '1;
      3:       return GAIN_W'($urandom_range(0, UNITY_GAIN));
      default: return GAIN_W'($urandom);
    endcase
  endfunction

  initial begin
    int                 sent;
    int                 n;
    logic [STEP_W-1:0]  step_val;
    logic [SHAPE_W-1:0] shape;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings, with a tick-low item in between
    push_item(1'b1);
    push_item(1'b0);
    push_item(1'b1);
    in_valid <= 1'b0;
    wait_idle();

    // half-turn steps on a square at unity: positive full scale clips, right silent
    set_config(32'h8000_0000, SHAPE_SQUARE, UNITY_GAIN, UNITY_GAIN, 1'b0);
    send_ticks(2);
    wait_idle();
    // frozen phase, gain and pan at maximum (pan clamps to unity)
    set_config('0, SHAPE_SAW, '1, '1, 1'b1);
    send_ticks(2);
    wait_idle();
    set_config(32'h4000_0000, SHAPE_TRIANGLE, UNITY_GAIN, '0, 1'b0);
    send_ticks(4);
    wait_idle();
    set_config('1, SHAPE_NOISE, UNITY_GAIN, RST_PAN, 1'b0);
    send_ticks(3);
    wait_idle();
    set_config(32'h1234_5678, SHAPE_UNUSED, UNITY_GAIN, RST_PAN, 1'b1);
    send_ticks(2);
    wait_idle();
    set_config(32'h0100_0000, SHAPE_SINE, '0, UNITY_GAIN, 1'b0);
    send_ticks(2);
    wait_idle();
    set_config(32'h3FC0_0000, SHAPE_SINE, UNITY_GAIN, 16'd20000, 1'b0);
    send_ticks(4);
    wait_idle();

    sent = 0;
    while (sent < RANDOM_TICKS) begin
      case ($urandom_range(0, 5))
        0:       step_val = '0;
        1:       step_val = 32'h8000_0000;
        2:       step_val = '1;
        3:       step_val = $urandom_range(1, 32'h00FF_FFFF);
        default: step_val = $urandom;
      endcase
      if ($urandom_range(0, 9) == 0)
        shape = SHAPE_W'($urandom_range(SHAPE_NOISE + 1, SHAPE_UNUSED));
      else
        shape = SHAPE_W'($urandom_range(SHAPE_SINE, SHAPE_NOISE));
      set_config(step_val, shape, pick_gain(), pick_gain(), $urandom_range(0, 3) == 0);
      n = $urandom_range(10, 60);
      send_ticks(n);
      sent += n;
      wait_idle();
    end

    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
